// ===== rtl/core/gimbal_pitch_slew_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Gimbal pitch slew controller assertion macros
// Shorthands for the checks at the end of the top level; they sample on clk
// and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef GIMBAL_PITCH_SLEW_CONTROLLER_UNIT_MACROS_SVH
`define GIMBAL_PITCH_SLEW_CONTROLLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define GPSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpsc_pkg
// Shared widths, codes, reset values and types of the pitch slew controller.
// ----------------------------------------------------------------------------
package gpsc_pkg;

  // Field widths
  localparam int ANGLE_W    = 16;
  localparam int STEP_W     = 15;
  localparam int TICKS_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default counter width
  localparam int COUNT_WIDTH_DEF = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PITCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 3'd4;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] MIN_PITCH_RST   = -16'sd9000;
  localparam logic signed [ANGLE_W-1:0] MAX_PITCH_RST   = 16'sd1500;
  localparam logic [STEP_W-1:0]         SLEW_STEP_RST   = 15'd44;
  localparam logic [TICKS_W-1:0]        DELAY_TICKS_RST = 10'd25;
  localparam logic [TICKS_W-1:0]        HOLD_TICKS_RST  = 10'd100;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_SLEW = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] min_pitch;
    logic signed [ANGLE_W-1:0] max_pitch;
    logic [STEP_W-1:0]         slew_step;
    logic [TICKS_W-1:0]        delay_ticks;
    logic [TICKS_W-1:0]        hold_ticks;
  } cfg_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [ANGLE_W-1:0] target_angle;
  } cmd_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch;
    phase_t                    phase;
    logic                      busy_res;
  } res_t;

  // Motion flags, exported for checking
  typedef struct packed {
    logic waiting;
    logic slewing;
  } stat_t;

endpackage

// ===== rtl/core/gpsc_ifs.sv =====
// ----------------------------------------------------------------------------
// gpsc channel interfaces
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface gpsc_cmd_if import gpsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [ANGLE_W-1:0] target_angle;

  modport source (output valid, operation, target_angle, input ready);
  modport sink   (input valid, operation, target_angle, output ready);
endinterface

interface gpsc_res_if import gpsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] pitch;
  logic [1:0]                phase;
  logic                      busy_res;

  modport source (output valid, pitch, phase, busy_res, input ready);
  modport sink   (input valid, pitch, phase, busy_res, output ready);
endinterface

// ===== rtl/core/gpsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gpsc_cfg_regs
// Configuration register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module gpsc_cfg_regs import gpsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pitch   <= MIN_PITCH_RST;
      cfg.max_pitch   <= MAX_PITCH_RST;
      cfg.slew_step   <= SLEW_STEP_RST;
      cfg.delay_ticks <= DELAY_TICKS_RST;
      cfg.hold_ticks  <= HOLD_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PITCH:   cfg.min_pitch   <= signed'(cfg_wdata[ANGLE_W-1:0]);
        CFG_MAX_PITCH:   cfg.max_pitch   <= signed'(cfg_wdata[ANGLE_W-1:0]);
        CFG_SLEW_STEP:   cfg.slew_step   <= cfg_wdata[STEP_W-1:0];
        CFG_DELAY_TICKS: cfg.delay_ticks <= cfg_wdata[TICKS_W-1:0];
        CFG_HOLD_TICKS:  cfg.hold_ticks  <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/gpsc_in_reg.sv =====
// ----------------------------------------------------------------------------
// gpsc_in_reg
// Input register for command beats; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module gpsc_in_reg import gpsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t in_item,
  output logic in_ready,
  input  logic take,
  output logic held_valid,
  output cmd_t held_item
);

  assign in_ready = !held_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== rtl/core/gpsc_slew_core.sv =====
// ----------------------------------------------------------------------------
// gpsc_slew_core
// Motion state and its next-state update: target clamp, start delay,
// rate-limited step toward the goal and busy hold counter.
// ----------------------------------------------------------------------------
module gpsc_slew_core import gpsc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  fire,
  input  cmd_t  item,
  output res_t  res_next,
  output stat_t stat
);

  localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic signed [ANGLE_W:0] wide_t;

  logic signed [ANGLE_W-1:0] pitch_now, pitch_now_next;
  logic signed [ANGLE_W-1:0] pitch_goal, pitch_goal_next;
  logic                      waiting, waiting_next;
  logic                      slewing, slewing_next;
  cnt_t                      wait_count, wait_count_next;
  cnt_t                      since_end, since_end_next;

  logic signed [ANGLE_W-1:0] clamp_hi, clamp_val;
  cnt_t                      wait_inc, since_inc;
  logic                      wait_after, move;
  wide_t                     err, up_val, dn_val;
  logic [ANGLE_W:0]          mag;
  logic                      snap;

  // Target clamp: upper limit first, lower limit wins when inverted
  assign clamp_hi  = (item.target_angle > cfg.max_pitch) ? cfg.max_pitch : item.target_angle;
  assign clamp_val = (clamp_hi < cfg.min_pitch) ? cfg.min_pitch : clamp_hi;

  // Saturating counters
  assign wait_inc  = (wait_count == '1) ? wait_count : wait_count + cnt_t'(1);
  assign since_inc = (since_end == '1) ? since_end : since_end + cnt_t'(1);

  // Delay check and step toward goal
  assign wait_after = waiting && (cmp_t'(wait_inc) < cmp_t'(cfg.delay_ticks));
  assign move       = !wait_after && slewing;
  assign err        = wide_t'(pitch_goal) - wide_t'(pitch_now);
  assign mag        = err[ANGLE_W] ? unsigned'(-err) : unsigned'(err);
  assign snap       = mag <= (ANGLE_W+1)'(cfg.slew_step);
  assign up_val     = wide_t'(pitch_now) + wide_t'(signed'({1'b0, cfg.slew_step}));
  assign dn_val     = wide_t'(pitch_now) - wide_t'(signed'({1'b0, cfg.slew_step}));

  // Next state
  always_comb begin
    pitch_now_next  = pitch_now;
    pitch_goal_next = pitch_goal;
    waiting_next    = waiting;
    slewing_next    = slewing;
    wait_count_next = wait_count;
    since_end_next  = since_end;
    if (fire) begin
      if (item.operation == OP_SET) begin
        pitch_goal_next = clamp_val;
        waiting_next    = 1'b1;
        slewing_next    = 1'b1;
        wait_count_next = '0;
      end else begin
        since_end_next = since_inc;
        if (waiting) begin
          wait_count_next = wait_inc;
          waiting_next    = wait_after;
        end
        if (move) begin
          if (snap) begin
            pitch_now_next = pitch_goal;
            slewing_next   = 1'b0;
            since_end_next = '0;
          end else if (!err[ANGLE_W]) begin
            pitch_now_next = up_val[ANGLE_W-1:0];
          end else begin
            pitch_now_next = dn_val[ANGLE_W-1:0];
          end
        end
      end
    end
  end

  // Result of a tick
  always_comb begin
    res_next.pitch = pitch_now_next;
    priority if (waiting_next) begin
      res_next.phase = PH_WAIT;
    end else if (slewing_next) begin
      res_next.phase = PH_SLEW;
    end else begin
      res_next.phase = PH_IDLE;
    end
    res_next.busy_res = waiting_next || slewing_next ||
                        (cmp_t'(since_end_next) < cmp_t'(cfg.hold_ticks));
  end

  assign stat.waiting = waiting;
  assign stat.slewing = slewing;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_now  <= '0;
      pitch_goal <= '0;
      waiting    <= 1'b0;
      slewing    <= 1'b0;
      wait_count <= '0;
      since_end  <= '0;
    end else begin
      pitch_now  <= pitch_now_next;
      pitch_goal <= pitch_goal_next;
      waiting    <= waiting_next;
      slewing    <= slewing_next;
      wait_count <= wait_count_next;
      since_end  <= since_end_next;
    end
  end

endmodule

// ===== rtl/core/gimbal_pitch_slew_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Gimbal pitch slew controller
// Takes one command beat per cycle unless stalled. A beat is held in the input
// register, then the motion state updates and a tick's result is loaded into
// the output register, so a result is valid in the cycle after its tick beat
// is taken. The output register and the input register both refill in the
// cycle they drain; the input side stalls only while a tick waits behind an
// untaken result. Set-target beats give no result. Busy is held after reset
// and after each completed move until the count of ticks since then reaches
// hold_ticks.
// ----------------------------------------------------------------------------
`include "gimbal_pitch_slew_controller_unit_macros.svh"

module gimbal_pitch_slew_controller_unit import gpsc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  gpsc_cmd_if.sink              cmd,
  gpsc_res_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg;
  cmd_t  in_item, held_item;
  logic  held_valid, take, held_tick;
  res_t  res_next, res_q;
  logic  out_valid;
  stat_t stat;

  // Configuration
  gpsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  assign in_item.operation    = op_t'(cmd.operation);
  assign in_item.target_angle = cmd.target_angle;

  gpsc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_item    (in_item),
    .in_ready   (cmd.ready),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // A tick may proceed when the output register is free or draining
  assign held_tick = held_item.operation == OP_TICK;
  assign take      = held_valid && (!held_tick || !out_valid || res.ready);

  gpsc_slew_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (take),
    .item     (held_item),
    .res_next (res_next),
    .stat     (stat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && held_tick) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_tick) begin
      res_q <= res_next;
    end
  end

  assign res.valid    = out_valid;
  assign res.pitch    = res_q.pitch;
  assign res.phase    = res_q.phase;
  assign res.busy_res = res_q.busy_res;

  // Checks
  `GPSC_ASSERT_SAME(a_no_overwrite, out_valid && !res.ready && held_valid && held_tick, !take, "gpsc: pending result overwritten")
  `GPSC_ASSERT_NEXT(a_tick_gives_beat, take && held_tick, out_valid, "gpsc: tick gave no result")
  `GPSC_ASSERT_SAME(a_wait_in_move, stat.waiting, stat.slewing, "gpsc: waiting outside a move")
  `GPSC_ASSERT_SAME(a_busy_when_moving, out_valid && res_q.phase != PH_IDLE, res_q.busy_res, "gpsc: moving but not busy")

endmodule
